FILE: hdl/assert_macros.svh
// Assertion macros shared by the RTL of this block.
// Define NO_ASSERTIONS to compile them out.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// The expression holds at every clock edge out of reset.
`define ASSERT_HOLDS(lbl, clk_sig, rstn_sig, expr) \
    lbl: assert property (@(posedge clk_sig) disable iff (!rstn_sig) (expr)) \
        else $error("assertion failed: expr");

// Whenever the antecedent holds, the consequent holds in the same cycle.
`define ASSERT_IMPLIES(lbl, clk_sig, rstn_sig, ante, cons) \
    lbl: assert property (@(posedge clk_sig) disable iff (!rstn_sig) (ante) |-> (cons)) \
        else $error("assertion failed: ante implies cons");

// Whenever the antecedent holds, the consequent holds in the next cycle.
`define ASSERT_NEXT(lbl, clk_sig, rstn_sig, ante, cons) \
    lbl: assert property (@(posedge clk_sig) disable iff (!rstn_sig) (ante) |=> (cons)) \
        else $error("assertion failed: ante then cons");

`else

`define ASSERT_HOLDS(lbl, clk_sig, rstn_sig, expr)
`define ASSERT_IMPLIES(lbl, clk_sig, rstn_sig, ante, cons)
`define ASSERT_NEXT(lbl, clk_sig, rstn_sig, ante, cons)

`endif

`endif

FILE: hdl/dfct_pkg.sv
package dfct_pkg;

    // Register indexes on the configuration port (byte address / 4).
    typedef enum logic [2:0] {
        REG_ENABLE         = 3'd0,
        REG_MIN_INTERVAL   = 3'd1,
        REG_REFRESH_BASE   = 3'd2,
        REG_REFRESH_STAGER = 3'd3,
        REG_DEADBAND       = 3'd4,
        REG_QUEUE_LIMIT    = 3'd5
    } reg_idx_t;

    // Register reset values.
    localparam logic        ENABLE_RST        = 1'b1;
    localparam logic [15:0] MIN_INTERVAL_RST  = 16'd200;
    localparam logic [15:0] REFRESH_BASE_RST  = 16'd5000;
    localparam logic [15:0] REFRESH_STAGR_RST = 16'd700;
    localparam logic [7:0]  DEADBAND_RST      = 8'd3;
    localparam logic [7:0]  QUEUE_LIMIT_RST   = 8'd24;

    // Strobe channel values above this enable strobing.
    localparam logic [7:0] STROBE_MIN = 8'd5;
    // First strobe value of the half-period table, and the last one above the floor.
    localparam logic [7:0] STROBE_TBL_LO = 8'd6;
    localparam logic [7:0] STROBE_TBL_HI = 8'd28;
    localparam int         HP_TBL_DEPTH  = 23;
    // Shortest strobe half-period in milliseconds (2 Hz ceiling).
    localparam logic [8:0] HALF_PERIOD_FLOOR = 9'd250;

    // Level byte of an on command carries this flag over brightness7.
    localparam logic [7:0] LEVEL_ON_FLAG = 8'h80;

    // floor(124500 / (249 + 11*k)) for strobe value 6+k.
    localparam logic [8:0] HP_TBL [HP_TBL_DEPTH] = '{
        9'd500, 9'd478, 9'd459, 9'd441, 9'd424, 9'd409, 9'd395, 9'd381,
        9'd369, 9'd357, 9'd346, 9'd336, 9'd326, 9'd317, 9'd308, 9'd300,
        9'd292, 9'd285, 9'd278, 9'd271, 9'd265, 9'd259, 9'd253
    };

    // Strobe half-period in milliseconds; strobe values past the table hit the floor.
    function automatic logic [8:0] half_period_ms(input logic [7:0] strobe);
        logic [7:0] ofs;
        ofs = strobe - STROBE_TBL_LO;
        if (strobe >= STROBE_TBL_LO && strobe <= STROBE_TBL_HI)
            return HP_TBL[ofs[4:0]];
        else
            return HALF_PERIOD_FLOOR;
    endfunction

    // Color plus white at 235/255, saturated to 255.
    // The divide by 255 uses (x + (x >> 8) + 1) >> 8, exact for x below 255*256.
    function automatic logic [7:0] blend_white(input logic [7:0] c, input logic [7:0] w);
        logic [15:0] x;
        logic [15:0] q;
        logic [8:0]  s;
        x = 16'(w) * 16'd235;
        q = (x + (x >> 8) + 16'd1) >> 8;
        s = 9'(c) + 9'(q[7:0]);
        return s[8] ? 8'hFF : s[7:0];
    endfunction

endpackage

FILE: hdl/dmx_flood_command_throttle_core.sv
// A tick waits in the input register; a command it yields is held in the result register.
// Throughput: one tick per cycle; only a stalled result register holds back input.
// Each tick does its per-flood state read-modify-write as it leaves the input register.
// Reset (rst_n low, asynchronous) restores the register defaults, clears the
// send history, sets every strobe phase to on and empties both pipeline stages.
`include "assert_macros.svh"

module dmx_flood_command_throttle_core #(
    parameter int NUM_FLOODS = 4
) (
    input  logic        clk,
    input  logic        rst_n,

    // Tick stream in.
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // [31:0] now_ms, [39:32] total_level, [47:40] red_in, [55:48] green_in,
    // [63:56] blue_in, [71:64] white_in, [79:72] strobe_in, [87:80] queue_depth
    input  logic [87:0] s_axis_tdata,
    // [1:0] flood_index
    input  logic [1:0]  s_axis_tuser,

    // Command stream out.
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // [7:0] level_byte, [15:8] blue_out, [23:16] red_out, [31:24] green_out
    output logic [31:0] m_axis_tdata,
    // [1:0] target_flood, [2] light_on
    output logic [2:0]  m_axis_tuser,

    // Configuration port.
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int IDX_W = (NUM_FLOODS > 1) ? $clog2(NUM_FLOODS) : 1;

    typedef struct packed {
        logic [7:0] level;
        logic [7:0] blue;
        logic [7:0] red;
        logic [7:0] green;
    } bytes_t;

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic        enable_reg;
    logic [15:0] min_interval_reg;
    logic [15:0] refresh_base_reg;
    logic [15:0] refresh_stagger_reg;
    logic [7:0]  deadband_reg;
    logic [7:0]  queue_limit_reg;
    logic        cfg_wr;
    logic [2:0]  cfg_idx;

    assign pready  = 1'b1;
    assign cfg_idx = paddr[4:2];
    assign cfg_wr  = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            enable_reg          <= dfct_pkg::ENABLE_RST;
            min_interval_reg    <= dfct_pkg::MIN_INTERVAL_RST;
            refresh_base_reg    <= dfct_pkg::REFRESH_BASE_RST;
            refresh_stagger_reg <= dfct_pkg::REFRESH_STAGR_RST;
            deadband_reg        <= dfct_pkg::DEADBAND_RST;
            queue_limit_reg     <= dfct_pkg::QUEUE_LIMIT_RST;
        end
        else if (cfg_wr)
        begin
            unique case (cfg_idx)
                dfct_pkg::REG_ENABLE:         enable_reg          <= pwdata[0];
                dfct_pkg::REG_MIN_INTERVAL:   min_interval_reg    <= pwdata[15:0];
                dfct_pkg::REG_REFRESH_BASE:   refresh_base_reg    <= pwdata[15:0];
                dfct_pkg::REG_REFRESH_STAGER: refresh_stagger_reg <= pwdata[15:0];
                dfct_pkg::REG_DEADBAND:       deadband_reg        <= pwdata[7:0];
                dfct_pkg::REG_QUEUE_LIMIT:    queue_limit_reg     <= pwdata[7:0];
                default: ;
            endcase
        end
    end

    // Register read-back.
    always_comb
    begin
        unique case (cfg_idx)
            dfct_pkg::REG_ENABLE:         prdata = {31'd0, enable_reg};
            dfct_pkg::REG_MIN_INTERVAL:   prdata = {16'd0, min_interval_reg};
            dfct_pkg::REG_REFRESH_BASE:   prdata = {16'd0, refresh_base_reg};
            dfct_pkg::REG_REFRESH_STAGER: prdata = {16'd0, refresh_stagger_reg};
            dfct_pkg::REG_DEADBAND:       prdata = {24'd0, deadband_reg};
            dfct_pkg::REG_QUEUE_LIMIT:    prdata = {24'd0, queue_limit_reg};
            default:                      prdata = 32'd0;
        endcase
    end

    // ------------------------------------------------------------------
    // Input register
    // ------------------------------------------------------------------
    logic        in_valid_reg;
    logic [87:0] in_data_reg;
    logic [1:0]  in_idx_reg;
    logic        out_valid_reg;
    logic        adv;
    logic        in_take;

    // The tick in the input register is processed once the result slot is free.
    assign adv           = in_valid_reg && (!out_valid_reg || m_axis_tready);
    assign s_axis_tready = !in_valid_reg || adv;
    assign in_take       = s_axis_tvalid && s_axis_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (s_axis_tready)
            in_valid_reg <= s_axis_tvalid;
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            in_data_reg <= s_axis_tdata;
            in_idx_reg  <= s_axis_tuser;
        end
    end

    // Field view of the held tick.
    logic [31:0] now_ms;
    logic [7:0]  total_level, red_in, green_in, blue_in, white_in, strobe_in, queue_depth;

    assign now_ms      = in_data_reg[31:0];
    assign total_level = in_data_reg[39:32];
    assign red_in      = in_data_reg[47:40];
    assign green_in    = in_data_reg[55:48];
    assign blue_in     = in_data_reg[63:56];
    assign white_in    = in_data_reg[71:64];
    assign strobe_in   = in_data_reg[79:72];
    assign queue_depth = in_data_reg[87:80];

    // ------------------------------------------------------------------
    // Per-flood state
    // ------------------------------------------------------------------
    logic [31:0] last_send_time_reg [NUM_FLOODS];
    logic [31:0] last_flip_time_reg [NUM_FLOODS];
    logic        strobe_phase_reg   [NUM_FLOODS];
    bytes_t      last_sent_reg      [NUM_FLOODS];
    logic        last_was_off_reg   [NUM_FLOODS];
    logic        ever_sent_reg      [NUM_FLOODS];

    logic [IDX_W-1:0] sel;
    logic             flood_ok;

    assign sel      = IDX_W'(in_idx_reg);
    assign flood_ok = (32'(in_idx_reg) < NUM_FLOODS);

    // ------------------------------------------------------------------
    // Tick evaluation
    // ------------------------------------------------------------------
    logic [31:0] since_send;
    logic [31:0] since_flip;
    logic        proceed;
    logic [7:0]  rr, gg, bb;
    logic        on_raw;
    logic        strobing;
    logic        flip;
    logic        phase_next;
    logic        on;
    bytes_t      desired;
    bytes_t      prev;
    logic [3:0]  byte_moved;
    logic        changed;
    logic [17:0] stagger_ofs;
    logic [31:0] repaint_limit;
    logic        send;

    assign since_send = now_ms - last_send_time_reg[sel];
    assign since_flip = now_ms - last_flip_time_reg[sel];
    assign proceed    = flood_ok && enable_reg && (since_send >= 32'(min_interval_reg));

    assign rr     = dfct_pkg::blend_white(red_in, white_in);
    assign gg     = dfct_pkg::blend_white(green_in, white_in);
    assign bb     = dfct_pkg::blend_white(blue_in, white_in);
    assign on_raw = (total_level != 8'd0) && ((rr | gg | bb) != 8'd0);

    // Strobe: toggle the phase once a half-period has passed since the last flip; without strobing the phase is on.
    assign strobing   = on_raw && (strobe_in > dfct_pkg::STROBE_MIN);
    assign flip       = strobing &&
                        (since_flip >= 32'(dfct_pkg::half_period_ms(strobe_in)));
    assign phase_next = strobing ? (strobe_phase_reg[sel] ^ flip) : 1'b1;
    assign on         = strobing ? phase_next : on_raw;

    assign desired.level = {1'b0, total_level[7:1]};
    assign desired.blue  = bb;
    assign desired.red   = rr;
    assign desired.green = gg;
    assign prev          = last_sent_reg[sel];

    // Deadband compare of each byte against what was last sent.
    always_comb
    begin
        byte_moved[3] = ((desired.level > prev.level) ? desired.level - prev.level
                                                       : prev.level - desired.level)
                        >= deadband_reg;
        byte_moved[2] = ((desired.blue > prev.blue) ? desired.blue - prev.blue
                                                     : prev.blue - desired.blue)
                        >= deadband_reg;
        byte_moved[1] = ((desired.red > prev.red) ? desired.red - prev.red
                                                   : prev.red - desired.red)
                        >= deadband_reg;
        byte_moved[0] = ((desired.green > prev.green) ? desired.green - prev.green
                                                       : prev.green - desired.green)
                        >= deadband_reg;
    end

    // A first send or an on/off flip always counts as a change.
    always_comb
    begin
        priority if (!ever_sent_reg[sel] || (on == last_was_off_reg[sel]))
            changed = 1'b1;
        else if (!on)
            changed = 1'b0;
        else
            changed = |byte_moved;
    end

    // Staggered repaint of unchanged state, then the queue check.
    assign stagger_ofs   = 18'(in_idx_reg) * 18'(refresh_stagger_reg);
    assign repaint_limit = 32'(refresh_base_reg) + 32'(stagger_ofs);
    assign send          = proceed && (changed || (since_send >= repaint_limit)) &&
                           (queue_depth < queue_limit_reg);

    // State write-back for the serviced flood.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_FLOODS; i++)
            begin
                last_send_time_reg[i] <= 32'd0;
                last_flip_time_reg[i] <= 32'd0;
                strobe_phase_reg[i]   <= 1'b1;
                last_sent_reg[i]      <= '0;
                last_was_off_reg[i]   <= 1'b0;
                ever_sent_reg[i]      <= 1'b0;
            end
        end
        else if (adv)
        begin
            if (proceed)
            begin
                strobe_phase_reg[sel] <= phase_next;
                if (flip)
                    last_flip_time_reg[sel] <= now_ms;
            end
            if (send)
            begin
                last_sent_reg[sel]      <= desired;
                last_was_off_reg[sel]   <= !on;
                ever_sent_reg[sel]      <= 1'b1;
                last_send_time_reg[sel] <= now_ms;
            end
        end
    end

    // ------------------------------------------------------------------
    // Result register
    // ------------------------------------------------------------------
    logic [31:0] out_data_reg;
    logic [2:0]  out_user_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (adv)
            out_valid_reg <= send;
        else if (m_axis_tready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (adv && send)
        begin
            out_user_reg <= {on, in_idx_reg};
            if (on)
                out_data_reg <= {desired.green, desired.red, desired.blue,
                                 dfct_pkg::LEVEL_ON_FLAG | desired.level};
            else
                out_data_reg <= 32'd0;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;
    assign m_axis_tuser  = out_user_reg;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    `ASSERT_IMPLIES(a_result_from_tick, clk, rst_n, $rose(out_valid_reg), $past(adv))
    `ASSERT_IMPLIES(a_off_cmd_dark, clk, rst_n, out_valid_reg && !out_user_reg[2], out_data_reg == 32'd0)
    `ASSERT_IMPLIES(a_on_cmd_flag, clk, rst_n, out_valid_reg && out_user_reg[2], out_data_reg[7])
    `ASSERT_NEXT(a_tick_held, clk, rst_n, in_valid_reg && !adv, in_valid_reg)
    `ASSERT_IMPLIES(a_send_needs_enable, clk, rst_n, adv && send, enable_reg && flood_ok)

endmodule
